/* hdl/stt_pkg.sv */
package stt_pkg;

    localparam int FIELD_W     = 20;
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = 3;
    localparam int NUM_CAND    = 6;

    typedef enum logic [3:0] {
        CLS_INT           = 4'd0,
        CLS_IDENT         = 4'd1,
        CLS_FUNCTION      = 4'd2,
        CLS_ASSIGN        = 4'd3,
        CLS_OPEN          = 4'd4,
        CLS_CLOSE         = 4'd5,
        CLS_BRACE_OPEN    = 4'd6,
        CLS_BRACE_CLOSE   = 4'd7,
        CLS_BRACKET_OPEN  = 4'd8,
        CLS_BRACKET_CLOSE = 4'd9,
        CLS_ARROW         = 4'd10,
        CLS_END           = 4'd11
    } t_token_class;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [3:0] KW_LEN = 4'd8;

    function automatic logic [7:0] f_kw_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h66;
            3'd1:    ch = 8'h75;
            3'd2:    ch = 8'h6E;
            3'd3:    ch = 8'h63;
            3'd4:    ch = 8'h74;
            3'd5:    ch = 8'h69;
            3'd6:    ch = 8'h6F;
            default: ch = 8'h6E;
        endcase
        return ch;
    endfunction

    // Returns CLS_INT when the byte is not a one-byte punctuation token.
    function automatic t_token_class f_single_class(input logic [7:0] c);
        t_token_class cls;
        case (c)
            CH_EQ:     cls = CLS_ASSIGN;
            CH_LPAREN: cls = CLS_OPEN;
            CH_RPAREN: cls = CLS_CLOSE;
            CH_LBRACE: cls = CLS_BRACE_OPEN;
            CH_RBRACE: cls = CLS_BRACE_CLOSE;
            CH_LBRACK: cls = CLS_BRACKET_OPEN;
            CH_RBRACK: cls = CLS_BRACKET_CLOSE;
            default:   cls = CLS_INT;
        endcase
        return cls;
    endfunction

    function automatic logic f_is_space(input logic [7:0] c);
        return c inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

endpackage

/* hdl/source_text_tokenizer.sv */
// Source text tokenizer: text bytes enter on the slave stream, one per beat, with tlast on the
// final byte of a text, and tokens leave on the master stream with tlast on the end token that
// closes each text. One byte is held back as lookahead, so the tokens a byte completes appear
// after the following byte (or the final byte) arrives. Each accepted byte is processed into
// a result register of up to four tokens, which drain one per cycle while the master is ready;
// a new byte is taken once the results are drained or their last token leaves, so the block
// sustains one byte per cycle and is only slowed where a byte yields more than one token or
// the master stalls. Offsets, lengths and line numbers saturate at 2^OFFSET_BITS-1 and are
// presented on 20-bit fields. After the end token all state returns to its reset values.
module source_text_tokenizer #(
    parameter int OFFSET_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // text_byte[7:0]
    input  logic        i_s_axis_tlast,   // text_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // token_class[3:0], token_offset[23:4], token_length[43:24], token_line[63:44],
    // token_column[83:64], zero pad[87:84]
    output logic [87:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast    // last_token
);

    localparam int OB = OFFSET_BITS;
    localparam int FW = stt_pkg::FIELD_W;

    typedef struct packed {
        logic [7:0]    held_byte;
        logic          held_valid;
        logic [OB-1:0] byte_offset;
        logic [OB-1:0] word_start;
        logic [OB-1:0] word_length;
        logic [OB-1:0] word_line;
        logic [OB-1:0] word_column;
        logic          word_first_digit;
        logic [3:0]    keyword_progress;
        logic          keyword_miss;
        logic [OB-1:0] line_count;
        logic [OB-1:0] newline_offset;
        logic          in_comment;
        logic          comment_star_seen;
        logic          skip_next;
    } t_state;

    typedef struct packed {
        stt_pkg::t_token_class cls;
        logic [OB-1:0]         off;
        logic [OB-1:0]         len;
        logic [OB-1:0]         line;
        logic [OB-1:0]         col;
        logic                  last;
    } t_token;

    typedef struct packed {
        t_state st;
        t_token tok;
        logic   v;
    } t_flush;

    typedef struct packed {
        t_state st;
        t_token t0;
        logic   v0;
        t_token t1;
        logic   v1;
    } t_proc;

    function automatic t_state f_reset_state();
        t_state s;
        s            = '0;
        s.word_line  = OB'(1);
        s.line_count = OB'(1);
        return s;
    endfunction

    function automatic logic [OB-1:0] f_sat(input logic [OB-1:0] x);
        return (&x) ? x : x + OB'(1);
    endfunction

    function automatic t_flush f_flush(input t_state s);
        t_flush r;
        r.st  = s;
        r.tok = '0;
        r.v   = 1'b0;
        if (s.word_length != '0) begin
            if (s.word_first_digit) begin
                r.tok.cls = stt_pkg::CLS_INT;
            end else if (!s.keyword_miss && s.keyword_progress == stt_pkg::KW_LEN) begin
                r.tok.cls = stt_pkg::CLS_FUNCTION;
            end else begin
                r.tok.cls = stt_pkg::CLS_IDENT;
            end
            r.tok.off  = s.word_start;
            r.tok.len  = s.word_length;
            r.tok.line = s.word_line;
            r.tok.col  = s.word_column;
            r.tok.last = 1'b0;
            r.v        = 1'b1;
            r.st.word_length      = '0;
            r.st.word_first_digit = 1'b0;
            r.st.keyword_progress = '0;
            r.st.keyword_miss     = 1'b0;
        end
        return r;
    endfunction

    function automatic t_state f_add_word(input t_state s, input logic [7:0] c,
                                          input logic [OB-1:0] off);
        t_state r;
        r = s;
        if (s.word_length == '0) begin
            r.word_start       = off;
            r.word_line        = s.line_count;
            r.word_column      = off - s.newline_offset;
            r.word_first_digit = stt_pkg::f_is_digit(c);
            r.keyword_progress = '0;
            r.keyword_miss     = 1'b0;
        end
        if (r.keyword_progress < stt_pkg::KW_LEN
                && stt_pkg::f_kw_char(r.keyword_progress[2:0]) == c) begin
            r.keyword_progress = r.keyword_progress + 4'd1;
        end else begin
            r.keyword_miss = 1'b1;
        end
        r.word_length = f_sat(s.word_length);
        return r;
    endfunction

    function automatic t_proc f_process(input t_state s, input logic [7:0] c,
                                        input logic has_next, input logic [7:0] nxt);
        t_proc                 r;
        t_flush                fl;
        logic [OB-1:0]         off;
        stt_pkg::t_token_class cls;
        logic                  is_single;
        logic                  arrow;
        logic                  opener;
        r.st      = s;
        r.t0      = '0;
        r.v0      = 1'b0;
        r.t1      = '0;
        r.v1      = 1'b0;
        off       = s.byte_offset;
        cls       = stt_pkg::f_single_class(c);
        is_single = (cls != stt_pkg::CLS_INT);
        arrow     = (c == stt_pkg::CH_MINUS) && has_next && (nxt == stt_pkg::CH_GT);
        opener    = (c == stt_pkg::CH_SLASH) && has_next && (nxt == stt_pkg::CH_STAR);
        r.st.byte_offset = f_sat(s.byte_offset);
        if (s.skip_next) begin
            r.st.skip_next = 1'b0;
        end else if (s.in_comment) begin
            if (s.comment_star_seen && c == stt_pkg::CH_SLASH) begin
                r.st.in_comment        = 1'b0;
                r.st.comment_star_seen = 1'b0;
            end else begin
                r.st.comment_star_seen = (c == stt_pkg::CH_STAR);
                if (c == stt_pkg::CH_LF) begin
                    r.st.line_count     = f_sat(s.line_count);
                    r.st.newline_offset = off;
                end
            end
        end else if (!(is_single || arrow || opener || stt_pkg::f_is_space(c))) begin
            r.st = f_add_word(r.st, c, off);
        end else begin
            if (c == stt_pkg::CH_LF) begin
                r.st.line_count     = f_sat(s.line_count);
                r.st.newline_offset = off;
            end
            fl   = f_flush(r.st);
            r.st = fl.st;
            r.t0 = fl.tok;
            r.v0 = fl.v;
            if (is_single || arrow) begin
                r.t1.cls  = is_single ? cls : stt_pkg::CLS_ARROW;
                r.t1.off  = off;
                r.t1.len  = is_single ? OB'(1) : OB'(2);
                r.t1.line = r.st.line_count;
                r.t1.col  = off - r.st.newline_offset;
                r.t1.last = 1'b0;
                r.v1      = 1'b1;
            end
            if (!is_single && arrow) begin
                r.st.skip_next = 1'b1;
            end
            if (opener) begin
                r.st.in_comment        = 1'b1;
                r.st.comment_star_seen = 1'b0;
            end
        end
        return r;
    endfunction

    t_state                    r_st;
    t_state                    n_st;
    t_token                    r_slot [stt_pkg::MAX_RESULTS];
    t_token                    n_slot [stt_pkg::MAX_RESULTS];
    logic [stt_pkg::CNT_W-1:0] r_cnt;
    logic [stt_pkg::CNT_W-1:0] n_cnt;
    logic [stt_pkg::CNT_W-1:0] r_rd;

    t_proc                     p_held;
    t_proc                     p_last;
    t_flush                    fl_last;
    t_token                    end_tok;
    t_token                    cand   [stt_pkg::NUM_CAND];
    logic                      cand_v [stt_pkg::NUM_CAND];
    logic                      s_fire;
    logic                      m_fire;
    t_token                    head;

    assign m_fire          = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tvalid = (r_rd != r_cnt);
    assign o_s_axis_tready = (r_rd == r_cnt)
                             || (m_fire && (r_rd + stt_pkg::CNT_W'(1) == r_cnt));
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        p_held = '0;
        p_held.st = r_st;
        if (r_st.held_valid) begin
            p_held = f_process(r_st, r_st.held_byte, 1'b1, i_s_axis_tdata);
        end
        p_last  = f_process(p_held.st, i_s_axis_tdata, 1'b0, 8'h00);
        fl_last = f_flush(p_last.st);

        end_tok.cls  = stt_pkg::CLS_END;
        end_tok.off  = p_held.st.byte_offset;
        end_tok.len  = OB'(1);
        end_tok.line = fl_last.st.line_count;
        end_tok.col  = p_held.st.byte_offset - fl_last.st.newline_offset;
        end_tok.last = 1'b1;

        cand[0]   = p_held.t0;
        cand_v[0] = p_held.v0;
        cand[1]   = p_held.t1;
        cand_v[1] = p_held.v1;
        cand[2]   = p_last.t0;
        cand_v[2] = p_last.v0 && i_s_axis_tlast;
        cand[3]   = p_last.t1;
        cand_v[3] = p_last.v1 && i_s_axis_tlast;
        cand[4]   = fl_last.tok;
        cand_v[4] = fl_last.v && i_s_axis_tlast;
        cand[5]   = end_tok;
        cand_v[5] = i_s_axis_tlast;

        n_slot = r_slot;
        n_cnt  = '0;
        for (int i = 0; i < stt_pkg::NUM_CAND; i++) begin
            if (cand_v[i] && n_cnt < stt_pkg::CNT_W'(stt_pkg::MAX_RESULTS)) begin
                n_slot[n_cnt[1:0]] = cand[i];
                n_cnt = n_cnt + stt_pkg::CNT_W'(1);
            end
        end

        if (i_s_axis_tlast) begin
            n_st = f_reset_state();
        end else begin
            n_st            = p_held.st;
            n_st.held_byte  = i_s_axis_tdata;
            n_st.held_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= f_reset_state();
            r_cnt <= '0;
            r_rd  <= '0;
        end else if (s_fire) begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
            r_rd  <= '0;
        end else if (m_fire) begin
            r_rd <= r_rd + stt_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_slot <= n_slot;
        end
    end

    assign head           = r_slot[r_rd[1:0]];
    assign o_m_axis_tdata = {4'b0000, FW'(head.col), FW'(head.line), FW'(head.len),
                             FW'(head.off), head.cls};
    assign o_m_axis_tlast = head.last;

`ifndef SYNTH
    a_rd_within_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd <= r_cnt && r_cnt <= stt_pkg::CNT_W'(stt_pkg::MAX_RESULTS))
        else $error("Result read pointer ran past the result count.");

    a_end_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_fire && o_m_axis_tlast) |-> (r_rd + stt_pkg::CNT_W'(1) == r_cnt))
        else $error("End token was not the final token of its beat.");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && i_s_axis_tlast) |=> (!r_st.held_valid && r_st.byte_offset == '0
                                        && o_m_axis_tvalid))
        else $error("State did not return to reset after the final byte.");

    a_last_beat_has_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && i_s_axis_tlast) |=> r_slot[r_cnt[1:0] - 2'd1].last)
        else $error("Final byte did not produce an end token.");
`endif

endmodule
